// ----- design/fdnp_pkg.sv -----
`default_nettype none
package fdnp_pkg;

  localparam int ARG_BITS   = 32;
  localparam int IN_ARG_BITS = 32;
  localparam int EXT_BITS   = (ARG_BITS > IN_ARG_BITS) ? ARG_BITS : IN_ARG_BITS;
  localparam int HEX_DIGITS = (ARG_BITS + 3) / 4;
  localparam int DEC_DIGITS = (ARG_BITS * 301) / 1000 + 1;
  localparam int DIG_BITS   = DEC_DIGITS * 4;
  localparam int HEX_SHIFT  = DIG_BITS - HEX_DIGITS * 4;
  localparam int CNT_BITS   = $clog2(ARG_BITS + 1);

  localparam int IN_TDATA_BITS  = ((8 + IN_ARG_BITS) + 7) / 8 * 8;
  localparam int OUT_TDATA_BITS = 8;

  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_C     = 8'h63;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_UPPER_A = 8'h41;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ONE,
    ST_SIGN,
    ST_CONV,
    ST_PRE0,
    ST_PREX,
    ST_DIGIT
  } state_t;

  typedef struct packed {
    logic ld_dec;
    logic ld_hex;
    logic conv;
    logic shift;
  } dig_ctl_t;

  function automatic logic [7:0] nib_to_char(input logic [3:0] nib);
    logic [7:0] c;
    if (nib > 4'd9) begin
      c = CH_UPPER_A + {4'd0, nib} - 8'd10;
    end else begin
      c = CH_ZERO + {4'd0, nib};
    end
    return c;
  endfunction

  function automatic logic [DIG_BITS-1:0] dabble(input logic [DIG_BITS-1:0] d);
    logic [DIG_BITS-1:0] r;
    r = d;
    for (int i = 0; i < DEC_DIGITS; i++) begin
      if (d[4*i +: 4] >= 4'd5) begin
        r[4*i +: 4] = d[4*i +: 4] + 4'd3;
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- design/format_directive_number_printer_top.sv -----
`default_nettype none
// channel  | ports                        | item
// in       | in_tvalid/in_tready/in_tdata | fmt_char [7:0], arg_value [39:8]
// out      | out_tvalid/out_tready/       | out_char [7:0], last_of_run on out_tlast
//          | out_tdata/out_tlast          |
// one item in at a time; a literal or 'c' emits one character, '%' emits none
// 'x': emits '0', 'x', then HEX_DIGITS hex digits with leading zeros dropped
// 'd': optional '-', ARG_BITS bit-serial bcd steps, then DEC_DIGITS scan/emit steps
// the bit-serial bcd converter in fdnp_digits produces the decimal digits
// reset: synchronous, active low; clears the directive flag and the sequencer
// a stalled out channel holds its item; the sequencer waits on the output register
module format_directive_number_printer_top (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [fdnp_pkg::IN_TDATA_BITS-1:0]  in_tdata,   // fmt_char, arg_value
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic [fdnp_pkg::OUT_TDATA_BITS-1:0]      out_tdata,  // out_char
  output logic                                     out_tlast
);
  import fdnp_pkg::*;

  state_t               state_r, state_nxt;
  logic                 after_pct_r, after_pct_nxt;
  logic [CNT_BITS-1:0]  cnt_r, cnt_nxt;
  logic                 lead_r, lead_nxt;
  logic [7:0]           one_r, one_nxt;
  logic                 out_valid_r;
  logic [7:0]           out_char_r;
  logic                 out_last_r;

  logic [7:0]                 in_char;
  logic signed [IN_ARG_BITS-1:0] in_arg;
  logic signed [EXT_BITS-1:0] arg_ext;
  logic [ARG_BITS-1:0]        arg_val;
  logic                       can_emit;
  logic                       emit;
  logic [7:0]                 emit_char;
  logic                       emit_last;
  dig_ctl_t                   ctl;
  logic [3:0]                 top_nib;

  assign in_char  = in_tdata[7:0];
  assign in_arg   = in_tdata[8 +: IN_ARG_BITS];
  assign arg_ext  = EXT_BITS'(in_arg);
  assign arg_val  = arg_ext[ARG_BITS-1:0];
  assign can_emit = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE);

  fdnp_digits u_digits (
    .clk     (clk),
    .ctl     (ctl),
    .val     (arg_val),
    .top_nib (top_nib)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      after_pct_r <= 1'b0;
      cnt_r       <= '0;
      lead_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      after_pct_r <= after_pct_nxt;
      cnt_r       <= cnt_nxt;
      lead_r      <= lead_nxt;
    end
  end

  always_ff @(posedge clk) begin
    one_r <= one_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    after_pct_nxt = after_pct_r;
    cnt_nxt       = cnt_r;
    lead_nxt      = lead_r;
    one_nxt       = one_r;
    ctl           = '0;
    emit          = 1'b0;
    emit_char     = '0;
    emit_last     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          if (!after_pct_r) begin
            if (in_char == CH_PCT) begin
              after_pct_nxt = 1'b1;
            end else begin
              one_nxt   = in_char;
              state_nxt = ST_ONE;
            end
          end else begin
            after_pct_nxt = 1'b0;
            priority if (in_char == CH_D) begin
              ctl.ld_dec = 1'b1;
              cnt_nxt    = CNT_BITS'(ARG_BITS);
              state_nxt  = arg_val[ARG_BITS-1] ? ST_SIGN : ST_CONV;
            end else if (in_char == CH_X) begin
              ctl.ld_hex = 1'b1;
              cnt_nxt    = CNT_BITS'(HEX_DIGITS);
              state_nxt  = ST_PRE0;
            end else if (in_char == CH_C) begin
              one_nxt   = arg_val[7:0];
              state_nxt = ST_ONE;
            end else begin
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      ST_ONE: begin
        if (can_emit) begin
          emit      = 1'b1;
          emit_char = one_r;
          emit_last = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_SIGN: begin
        if (can_emit) begin
          emit      = 1'b1;
          emit_char = CH_MINUS;
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        ctl.conv = 1'b1;
        cnt_nxt  = cnt_r - 1'b1;
        if (cnt_r == CNT_BITS'(1)) begin
          cnt_nxt   = CNT_BITS'(DEC_DIGITS);
          lead_nxt  = 1'b1;
          state_nxt = ST_DIGIT;
        end
      end
      ST_PRE0: begin
        if (can_emit) begin
          emit      = 1'b1;
          emit_char = CH_ZERO;
          state_nxt = ST_PREX;
        end
      end
      ST_PREX: begin
        if (can_emit) begin
          emit      = 1'b1;
          emit_char = CH_X;
          lead_nxt  = 1'b1;
          state_nxt = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        if (lead_r && (top_nib == 4'd0) && (cnt_r != CNT_BITS'(1))) begin
          // leading zero digit, dropped
          ctl.shift = 1'b1;
          cnt_nxt   = cnt_r - 1'b1;
        end else if (can_emit) begin
          emit      = 1'b1;
          emit_char = nib_to_char(top_nib);
          emit_last = (cnt_r == CNT_BITS'(1));
          lead_nxt  = 1'b0;
          ctl.shift = 1'b1;
          cnt_nxt   = cnt_r - 1'b1;
          if (cnt_r == CNT_BITS'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_char_r <= emit_char;
      out_last_r <= emit_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_char_r;
  assign out_tlast  = out_last_r;

endmodule
`default_nettype wire

// ----- design/fdnp_digits.sv -----
`default_nettype none
module fdnp_digits (
  input  wire logic                          clk,
  input  wire fdnp_pkg::dig_ctl_t            ctl,
  input  wire logic [fdnp_pkg::ARG_BITS-1:0] val,
  output logic [3:0]                         top_nib
);
  import fdnp_pkg::*;

  logic [ARG_BITS-1:0] mag_r;
  logic [DIG_BITS-1:0] dig_r;
  logic [ARG_BITS-1:0] abs_val;
  logic [DIG_BITS-1:0] dab;

  assign abs_val = val[ARG_BITS-1] ? (~val + 1'b1) : val;
  assign dab     = dabble(dig_r);
  assign top_nib = dig_r[DIG_BITS-1 -: 4];

  // bit-serial binary to bcd or a direct hex load, then nibble shift-out from the top
  always_ff @(posedge clk) begin
    if (ctl.ld_dec) begin
      mag_r <= abs_val;
      dig_r <= '0;
    end else if (ctl.ld_hex) begin
      dig_r <= DIG_BITS'(val) << HEX_SHIFT;
    end else if (ctl.conv) begin
      dig_r <= {dab[DIG_BITS-2:0], mag_r[ARG_BITS-1]};
      mag_r <= mag_r << 1;
    end else if (ctl.shift) begin
      dig_r <= dig_r << 4;
    end
  end

endmodule
`default_nettype wire

// ----- design/fdnp_checker.sv -----
`default_nettype none
module fdnp_checker (
  input wire logic                                clk,
  input wire logic                                rst_n,
  input wire logic                                in_tvalid,
  input wire logic                                in_tready,
  input wire logic [fdnp_pkg::IN_TDATA_BITS-1:0]  in_tdata,
  input wire logic                                out_tvalid,
  input wire logic                                out_tready,
  input wire logic [fdnp_pkg::OUT_TDATA_BITS-1:0] out_tdata,
  input wire logic                                out_tlast
);
  import fdnp_pkg::*;

  logic [7:0] oc;
  logic       mid_char_ok;

  assign oc = out_tdata[7:0];
  assign mid_char_ok = (oc == CH_MINUS) || (oc == CH_X) ||
                       ((oc >= CH_ZERO) && (oc <= 8'h39)) ||
                       ((oc >= CH_UPPER_A) && (oc <= 8'h46));

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("out item changed while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("out valid after reset");

  a_ready_after_run: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready && out_tvalid |-> out_tlast)
    else $error("new item taken before run finished");

  a_mid_run_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> mid_char_ok)
    else $error("unexpected character inside a number");

endmodule

bind format_directive_number_printer_top fdnp_checker u_fdnp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
`default_nettype wire
